>>> hdl/olde_pkg.sv
// Shared codes, widths and defaults for the ordered list deque engine.
`timescale 1ns / 1ps

package olde_pkg;

  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 16;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 5;

  typedef enum logic [OP_W-1:0] {
    OP_ADD_FRONT = 3'd0,
    OP_ADD_BACK  = 3'd1,
    OP_REM_FRONT = 3'd2,
    OP_REM_BACK  = 3'd3,
    OP_REM_MATCH = 3'd4,
    OP_COUNT     = 3'd5,
    OP_CLEAR     = 3'd6,
    OP_PEEK      = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

endpackage

>>> hdl/olde_ram.sv
// Entry store: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module olde_ram import olde_pkg::*; #(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int WIDTH = DEF_DATA_WIDTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/ordered_list_deque_engine.sv
// Top level: bounded ordered list with deque, match-remove and count operations.
//
// Usage
//   Input words (in_operation, in_value) are taken when in_valid is high and
//   in_stall is low. Every word yields exactly one result word on the out_
//   channel: status, front and back values (zero when empty), size, and the
//   number of matches for a count operation.
//   The list lives in a ring of CAPACITY slots in a single-port-read memory.
//   Add, remove at either end, clear and peek present their result after the
//   end values are re-read from memory, one read per cycle. When the list is
//   empty afterward the reads are skipped. Count and match removal scan the
//   list one entry per cycle through the memory read port. In a match removal
//   that closes up later entries, the close-up replaces the rest of the scan.
//   One word is in work at a time; in_stall is high from accept until the
//   result is loaded into the output register, so a new word is taken at the
//   earliest in the cycle after the load. The output register holds a result
//   while out_stall is high, and the next word may be accepted then.
//   Reset (rst_n low, synchronous) empties the list and drops any pending
//   result; no memory clearing pass is needed.
`timescale 1ns / 1ps

module ordered_list_deque_engine import olde_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [DATA_WIDTH-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [DATA_WIDTH-1:0] out_front_value,
  output logic [DATA_WIDTH-1:0] out_back_value,
  output logic [SIZE_W-1:0]     out_size,
  output logic [SIZE_W-1:0]     out_match_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = AW + 1;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN    = 7'b0000010,
    S_SHIFT   = 7'b0000100,
    S_FETCH_F = 7'b0001000,
    S_FETCH_B = 7'b0010000,
    S_FETCH_W = 7'b0100000,
    S_DONE    = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [AW-1:0]       front_r, front_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                cnt_op_r, cnt_op_nxt;
  logic [CW-1:0]       iss_pos_r, iss_pos_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic [CW-1:0]       rd_pos_r, rd_pos_nxt;
  logic [CW-1:0]       mcnt_r, mcnt_nxt;
  logic [DATA_WIDTH-1:0] fv_r, fv_nxt;
  logic [DATA_WIDTH-1:0] bv_r, bv_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [DATA_WIDTH-1:0] out_front_r, out_back_r;
  logic [SIZE_W-1:0]   out_size_r, out_mcnt_r;
  logic                out_load;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_wa, mem_ra;
  logic [DATA_WIDTH-1:0] mem_wd, mem_rd;

  // ring slot of logical position pos; sum stays below twice the capacity
  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] base,
                                           input logic [CW-1:0] pos);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(pos);
    if (sum >= SW'(CAPACITY)) begin
      sum = sum - SW'(CAPACITY);
    end
    return AW'(sum);
  endfunction

  olde_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  // sequencer: operation decode, scan, close-up and end-value fetch
  always_comb begin
    logic is_full;
    logic is_empty;
    logic hit;
    logic last;
    is_full     = (count_r == CW'(CAPACITY));
    is_empty    = (count_r == '0);
    hit         = rd_vld_r && (mem_rd == val_r);
    last        = rd_vld_r && (rd_pos_r == count_r - CW'(1));
    state_nxt   = state_r;
    front_nxt   = front_r;
    count_nxt   = count_r;
    status_nxt  = status_r;
    val_nxt     = val_r;
    cnt_op_nxt  = cnt_op_r;
    iss_pos_nxt = iss_pos_r;
    rd_vld_nxt  = 1'b0;
    rd_pos_nxt  = rd_pos_r;
    mcnt_nxt    = mcnt_r;
    fv_nxt      = fv_r;
    bv_nxt      = bv_r;
    mem_we      = 1'b0;
    mem_wa      = slot_f(front_r, rd_pos_r - CW'(1));
    mem_wd      = mem_rd;
    mem_re      = 1'b0;
    mem_ra      = slot_f(front_r, iss_pos_r);
    out_load    = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt     = in_value;
          status_nxt  = ST_OK;
          mcnt_nxt    = '0;
          iss_pos_nxt = '0;
          cnt_op_nxt  = 1'b0;
          state_nxt   = S_FETCH_F;
          case (op_t'(in_operation))
            OP_ADD_FRONT: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                front_nxt = (front_r == '0) ? AW'(CAPACITY - 1) : front_r - AW'(1);
                mem_we    = 1'b1;
                mem_wa    = front_nxt;
                mem_wd    = in_value;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_ADD_BACK: begin
              if (is_full) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = slot_f(front_r, count_r);
                mem_wd    = in_value;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_REM_FRONT: begin
              if (is_empty) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                front_nxt = (front_r == AW'(CAPACITY - 1)) ? '0 : front_r + AW'(1);
                count_nxt = count_r - CW'(1);
              end
            end
            OP_REM_BACK: begin
              if (is_empty) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            OP_REM_MATCH: begin
              if (is_empty) begin
                status_nxt = ST_NOT_FOUND;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_COUNT: begin
              cnt_op_nxt = 1'b1;
              if (!is_empty) begin
                state_nxt = S_SCAN;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              front_nxt = '0;
            end
            OP_PEEK: begin
              if (is_empty) begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              status_nxt = ST_OK;
            end
          endcase
        end
      end

      // one read issued per cycle while entries remain and no removal hit, compare on returned word
      S_SCAN: begin
        if (!cnt_op_r && hit) begin
          iss_pos_nxt = rd_pos_r + CW'(1);
          if (last) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_FETCH_F;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else begin
          if (iss_pos_r < count_r) begin
            mem_re      = 1'b1;
            iss_pos_nxt = iss_pos_r + CW'(1);
            rd_vld_nxt  = 1'b1;
            rd_pos_nxt  = iss_pos_r;
          end
          if (cnt_op_r && hit) begin
            mcnt_nxt = mcnt_r + CW'(1);
          end
          if (last) begin
            state_nxt = S_FETCH_F;
            if (!cnt_op_r) begin
              status_nxt = ST_NOT_FOUND;
            end
          end
        end
      end

      // close up: read position i+1, write it to position i next cycle
      S_SHIFT: begin
        if (iss_pos_r < count_r) begin
          mem_re      = 1'b1;
          iss_pos_nxt = iss_pos_r + CW'(1);
          rd_vld_nxt  = 1'b1;
          rd_pos_nxt  = iss_pos_r;
        end
        if (rd_vld_r) begin
          mem_we = 1'b1;
          if (last) begin
            count_nxt = count_r - CW'(1);
            state_nxt = S_FETCH_F;
          end
        end
      end

      S_FETCH_F: begin
        if (is_empty) begin
          fv_nxt    = '0;
          bv_nxt    = '0;
          state_nxt = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_ra    = front_r;
          state_nxt = S_FETCH_B;
        end
      end

      S_FETCH_B: begin
        mem_re    = 1'b1;
        mem_ra    = slot_f(front_r, count_r - CW'(1));
        fv_nxt    = mem_rd;
        state_nxt = S_FETCH_W;
      end

      S_FETCH_W: begin
        bv_nxt    = mem_rd;
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working payload
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    val_r     <= val_nxt;
    cnt_op_r  <= cnt_op_nxt;
    iss_pos_r <= iss_pos_nxt;
    rd_pos_r  <= rd_pos_nxt;
    mcnt_r    <= mcnt_nxt;
    fv_r      <= fv_nxt;
    bv_r      <= bv_nxt;
  end

  // result word
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      out_front_r  <= fv_r;
      out_back_r   <= bv_r;
      out_size_r   <= SIZE_W'(count_r);
      out_mcnt_r   <= SIZE_W'(mcnt_r);
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_front_value = out_front_r;
  assign out_back_value  = out_back_r;
  assign out_size        = out_size_r;
  assign out_match_count = out_mcnt_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again before the result was loaded");

  a_no_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_wa != mem_ra))
    else $error("read and write hit the same slot");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the done state");

  a_shift_reads_ahead: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && rd_vld_r) |-> (rd_pos_r != '0))
    else $error("close-up wrote before the front");

endmodule
